>>> rtl/core/rpsb_pkg.sv
`default_nettype none

package rpsb_pkg;

    localparam int MAX_SPRITE_SIZE_DEF = 1024;
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

    typedef enum logic [1:0] {
        ACT_PALETTE = 2'd0,
        ACT_START   = 2'd1,
        ACT_DATA    = 2'd2
    } act_t;

    typedef enum logic [2:0] {
        REG_CLIP_LEFT   = 3'd0,
        REG_CLIP_TOP    = 3'd1,
        REG_CLIP_RIGHT  = 3'd2,
        REG_CLIP_BOTTOM = 3'd3,
        REG_TRANSPARENT = 3'd4,
        REG_ROW_PITCH   = 3'd5,
        REG_FRAME_BASE  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [11:0] clip_left;
        logic [11:0] clip_top;
        logic [11:0] clip_right;
        logic [11:0] clip_bottom;
        logic [7:0]  transparent_code;
        logic [13:0] row_pitch_bytes;
        logic [31:0] frame_base;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        clip_left:        12'd0,
        clip_top:         12'd0,
        clip_right:       12'd639,
        clip_bottom:      12'd479,
        transparent_code: 8'd0,
        row_pitch_bytes:  14'd1280,
        frame_base:       32'd0
    };

    typedef struct packed {
        logic        hit;
        logic [31:0] addr;
    } pix_req_t;

endpackage

`default_nettype wire

>>> rtl/core/rpsb_palette.sv
`default_nettype none

module rpsb_palette (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [rpsb_pkg::PAL_AW-1:0] waddr,
    input  wire logic [15:0]               wdata,
    input  wire logic                      re,
    input  wire logic [rpsb_pkg::PAL_AW-1:0] raddr,
    output logic [15:0]                    rdata
);
    import rpsb_pkg::*;

    logic [15:0] mem [PALETTE_ENTRIES];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/rpsb_decode.sv
`default_nettype none

module rpsb_decode #(
    parameter int MAX_SPRITE_SIZE = rpsb_pkg::MAX_SPRITE_SIZE_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic [1:0]         action,
    input  wire logic [7:0]         data_byte,
    input  wire logic signed [11:0] pos_x,
    input  wire logic signed [11:0] pos_y,
    input  wire logic [10:0]        sprite_width,
    input  wire logic [10:0]        sprite_height,
    input  wire logic               mirror,
    input  wire logic               clip_enable,
    input  wire logic [31:0]        target_base,
    input  wire rpsb_pkg::cfg_t     cfg,
    output rpsb_pkg::pix_req_t      req
);
    import rpsb_pkg::*;

    localparam int SPAN_W = $clog2(MAX_SPRITE_SIZE + 1);
    localparam int SUM_W = ((SPAN_W > 8) ? SPAN_W : 8) + 1;
    localparam logic [13:0] MAX_EXT = 14'(MAX_SPRITE_SIZE);

    logic              active_reg, active_next;
    logic              skip_reg, skip_next;
    logic              mirrored_reg, mirrored_next;
    logic [SPAN_W-1:0] column_reg, column_next;
    logic [SPAN_W-1:0] row_index_reg, row_index_next;
    logic [SPAN_W-1:0] span_reg, span_next;
    logic [SPAN_W-1:0] first_reg, first_next;
    logic [SPAN_W-1:0] rows_reg, rows_next;
    logic [SPAN_W-1:0] lo_reg, lo_next;
    logic [SPAN_W-1:0] hi_reg, hi_next;
    logic [31:0]       row_addr_reg, row_addr_next;

    logic [13:0]        w_ext, h_ext, w_sat, h_sat;
    logic signed [13:0] w_s, h_s, x_s, y_s, x2_s, y2_s;
    logic signed [13:0] cl_s, ct_s, cr_s, cb_s;
    logic signed [13:0] first_s, rows_s, lo_s, hi_s;
    logic               hidden;
    logic [12:0]        pitch;
    logic signed [25:0] prod;
    logic [31:0]        base_sel, start_addr;

    logic              is_data, is_tc, is_pixel;
    logic [SPAN_W-1:0] j;
    logic [SPAN_W-1:0] row_inc;
    logic [SUM_W-1:0]  col_sum;
    logic              row_done;

    // Sprite start: saturate the size, clip against the rectangle, find the first row address.
    always_comb
    begin
        w_ext = {3'b000, sprite_width};
        h_ext = {3'b000, sprite_height};
        w_sat = (w_ext > MAX_EXT) ? MAX_EXT : w_ext;
        h_sat = (h_ext > MAX_EXT) ? MAX_EXT : h_ext;
        w_s = signed'(w_sat);
        h_s = signed'(h_sat);
        x_s = {{2{pos_x[11]}}, pos_x};
        y_s = {{2{pos_y[11]}}, pos_y};
        x2_s = x_s + w_s - 14'sd1;
        y2_s = y_s + h_s - 14'sd1;
        cl_s = {{2{cfg.clip_left[11]}}, cfg.clip_left};
        ct_s = {{2{cfg.clip_top[11]}}, cfg.clip_top};
        cr_s = {{2{cfg.clip_right[11]}}, cfg.clip_right};
        cb_s = {{2{cfg.clip_bottom[11]}}, cfg.clip_bottom};
        hidden = (w_sat == 14'd0) || (h_sat == 14'd0) ||
                 (clip_enable && ((x_s > cr_s) || (x2_s < cl_s) ||
                                  (y_s > cb_s) || (y2_s < ct_s)));
        first_s = (clip_enable && (y_s < ct_s)) ? (ct_s - y_s) : 14'sd0;
        rows_s = (clip_enable && (y2_s > cb_s)) ? (cb_s - y_s + 14'sd1) : h_s;
        lo_s = (clip_enable && (x_s < cl_s)) ? (cl_s - x_s) : 14'sd0;
        hi_s = (clip_enable && (x2_s > cr_s)) ? (cr_s - x_s) : (w_s - 14'sd1);
        pitch = cfg.row_pitch_bytes[13:1];
        prod = pos_y * $signed({1'b0, pitch});
        base_sel = (target_base == 32'd0) ? cfg.frame_base : target_base;
        start_addr = base_sel + {{6{prod[25]}}, prod} + {{20{pos_x[11]}}, pos_x};
    end

    // Stream byte: pixel, skip marker or skip count.
    always_comb
    begin
        is_data = (action == ACT_DATA) && active_reg;
        is_tc = (data_byte == cfg.transparent_code);
        is_pixel = is_data && !skip_reg && !is_tc;
        j = mirrored_reg ? (span_reg - SPAN_W'(1) - column_reg) : column_reg;
        row_inc = row_index_reg + SPAN_W'(1);
        if (skip_reg)
        begin
            col_sum = SUM_W'(column_reg) + SUM_W'(data_byte);
        end
        else
        begin
            col_sum = SUM_W'(column_reg) + SUM_W'(1);
        end
        row_done = (col_sum >= SUM_W'(span_reg));
        req.hit = is_pixel && (row_index_reg >= first_reg) && (j >= lo_reg) && (j <= hi_reg);
        req.addr = row_addr_reg + 32'(j);
    end

    always_comb
    begin
        active_next = active_reg;
        skip_next = skip_reg;
        mirrored_next = mirrored_reg;
        column_next = column_reg;
        row_index_next = row_index_reg;
        span_next = span_reg;
        first_next = first_reg;
        rows_next = rows_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        row_addr_next = row_addr_reg;
        case (action)
            ACT_START:
            begin
                skip_next = 1'b0;
                column_next = '0;
                row_index_next = '0;
                active_next = !hidden;
                if (!hidden)
                begin
                    mirrored_next = mirror;
                    span_next = w_sat[SPAN_W-1:0];
                    first_next = first_s[SPAN_W-1:0];
                    rows_next = rows_s[SPAN_W-1:0];
                    lo_next = lo_s[SPAN_W-1:0];
                    hi_next = hi_s[SPAN_W-1:0];
                    row_addr_next = start_addr;
                end
            end
            ACT_DATA:
            begin
                if (active_reg)
                begin
                    if (skip_reg || !is_tc)
                    begin
                        skip_next = 1'b0;
                        if (row_done)
                        begin
                            column_next = '0;
                            row_index_next = row_inc;
                            row_addr_next = row_addr_reg + {19'd0, pitch};
                            if (row_inc >= rows_reg)
                            begin
                                active_next = 1'b0;
                            end
                        end
                        else
                        begin
                            column_next = col_sum[SPAN_W-1:0];
                        end
                    end
                    else
                    begin
                        skip_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            skip_reg <= 1'b0;
            mirrored_reg <= 1'b0;
            column_reg <= '0;
            row_index_reg <= '0;
            span_reg <= '0;
            first_reg <= '0;
            rows_reg <= '0;
            lo_reg <= '0;
            hi_reg <= '0;
            row_addr_reg <= '0;
        end
        else if (step)
        begin
            active_reg <= active_next;
            skip_reg <= skip_next;
            mirrored_reg <= mirrored_next;
            column_reg <= column_next;
            row_index_reg <= row_index_next;
            span_reg <= span_next;
            first_reg <= first_next;
            rows_reg <= rows_next;
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            row_addr_reg <= row_addr_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rle_palette_sprite_blitter_unit.sv
// An accepted input word waits in the input register; its result word, if any, then waits in the output register.
// Throughput: one input word per cycle unless stalled; each needs one registered palette read.
// The input register and output register stall together only while a result word waits.
// Reset clears the handshake state and sprite state and loads the register defaults.
// Palette contents are undefined after reset until each entry is written.
`default_nettype none

module rle_palette_sprite_blitter_unit #(
    parameter int MAX_SPRITE_SIZE = rpsb_pkg::MAX_SPRITE_SIZE_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         action,
    input  wire logic [7:0]         data_byte,
    input  wire logic [15:0]        palette_color,
    input  wire logic signed [11:0] pos_x,
    input  wire logic signed [11:0] pos_y,
    input  wire logic [10:0]        sprite_width,
    input  wire logic [10:0]        sprite_height,
    input  wire logic               mirror,
    input  wire logic               clip_enable,
    input  wire logic [31:0]        target_base,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [31:0]             pixel_address,
    output logic [15:0]             pixel_color,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    import rpsb_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic               s1_valid_reg, s1_valid_next;
    logic [1:0]         act_reg;
    logic [7:0]         byte_reg;
    logic [15:0]        color_reg;
    logic signed [11:0] pos_x_reg, pos_y_reg;
    logic [10:0]        width_reg, height_reg;
    logic               mirror_reg, clip_en_reg;
    logic [31:0]        base_reg;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] addr_reg;

    logic     advance, in_take, step;
    pix_req_t req;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_CLIP_LEFT:   cfg_next.clip_left = cfg_data[11:0];
                REG_CLIP_TOP:    cfg_next.clip_top = cfg_data[11:0];
                REG_CLIP_RIGHT:  cfg_next.clip_right = cfg_data[11:0];
                REG_CLIP_BOTTOM: cfg_next.clip_bottom = cfg_data[11:0];
                REG_TRANSPARENT: cfg_next.transparent_code = cfg_data[7:0];
                REG_ROW_PITCH:   cfg_next.row_pitch_bytes = cfg_data[13:0];
                REG_FRAME_BASE:  cfg_next.frame_base = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign advance = !out_valid_reg || out_ready;
    assign step = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;
    assign in_take = in_valid && in_ready;

    always_comb
    begin
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        if (advance)
        begin
            out_valid_next = step && req.hit;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            act_reg <= action;
            byte_reg <= data_byte;
            color_reg <= palette_color;
            pos_x_reg <= pos_x;
            pos_y_reg <= pos_y;
            width_reg <= sprite_width;
            height_reg <= sprite_height;
            mirror_reg <= mirror;
            clip_en_reg <= clip_enable;
            base_reg <= target_base;
        end
        if (step && req.hit)
        begin
            addr_reg <= req.addr;
        end
    end

    rpsb_decode #(
        .MAX_SPRITE_SIZE(MAX_SPRITE_SIZE)
    ) u_decode (
        .clk(clk),
        .rst_n(rst_n),
        .step(step),
        .action(act_reg),
        .data_byte(byte_reg),
        .pos_x(pos_x_reg),
        .pos_y(pos_y_reg),
        .sprite_width(width_reg),
        .sprite_height(height_reg),
        .mirror(mirror_reg),
        .clip_enable(clip_en_reg),
        .target_base(base_reg),
        .cfg(cfg_reg),
        .req(req)
    );

    rpsb_palette u_palette (
        .clk(clk),
        .we(step && (act_reg == ACT_PALETTE)),
        .waddr(byte_reg),
        .wdata(color_reg),
        .re(step),
        .raddr(byte_reg),
        .rdata(pixel_color)
    );

    assign out_valid = out_valid_reg;
    assign pixel_address = addr_reg;

endmodule

`default_nettype wire

>>> rtl/core/rpsb_checker.sv
`default_nettype none

module rpsb_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] pixel_address,
    input wire logic [15:0] pixel_color
);

    // A stalled result word keeps its valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pixel_address) && $stable(pixel_color))
        else $error("result payload changed while stalled");

    // The input side never stalls while the output side takes words.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled with output ready");

    // A new result word appears only after the word that caused it was accepted and passed through the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result word without matching input word");

endmodule

bind rle_palette_sprite_blitter_unit rpsb_checker u_rpsb_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel_address(pixel_address),
    .pixel_color(pixel_color)
);

`default_nettype wire

>>> dv/tb.sv
`default_nettype none

module tb;
    import rpsb_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int SIZE_CAP = MAX_SPRITE_SIZE_DEF;
    localparam int PHASE_WORDS = 40;
    localparam int SETTINGS_COUNT = 7;
    localparam int QUIET_LIMIT = 2000;

    typedef struct {
        logic [1:0]  action;
        logic [7:0]  data_byte;
        logic [15:0] palette_color;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic [10:0] sprite_width;
        logic [10:0] sprite_height;
        logic        mirror;
        logic        clip_enable;
        logic [31:0] target_base;
    } blit_word_t;

    typedef struct {
        logic [31:0] addr;
        logic [15:0] color;
    } pixel_write_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOKED} rx_mode_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  action = ACT_PALETTE;
    logic [7:0]  data_byte = '0;
    logic [15:0] palette_color = '0;
    logic [11:0] pos_x = '0;
    logic [11:0] pos_y = '0;
    logic [10:0] sprite_width = '0;
    logic [10:0] sprite_height = '0;
    logic        mirror = 1'b0;
    logic        clip_enable = 1'b0;
    logic [31:0] target_base = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] pixel_address;
    logic [15:0] pixel_color;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    rle_palette_sprite_blitter_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .data_byte     (data_byte),
        .palette_color (palette_color),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .sprite_width  (sprite_width),
        .sprite_height (sprite_height),
        .mirror        (mirror),
        .clip_enable   (clip_enable),
        .target_base   (target_base),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Shadow of the block: registers, palette and the sprite walk.
    int          clip_l = 0;
    int          clip_t = 0;
    int          clip_r = 639;
    int          clip_b = 479;
    logic [7:0]  skip_code = 8'd0;
    logic [13:0] pitch_bytes = 14'd1280;
    logic [31:0] fb_base = '0;
    logic [15:0] pal_color [PALETTE_ENTRIES];
    bit          pal_loaded [PALETTE_ENTRIES];
    logic [7:0]  loaded_idx [$];
    bit          spr_on = 1'b0;
    bit          skip_wait = 1'b0;
    bit          spr_mirror = 1'b0;
    int          col = 0;
    int          row = 0;
    int          spr_w = 0;
    int          row_first = 0;
    int          row_count = 0;
    int          vis_lo = 0;
    int          vis_hi = 0;
    logic [31:0] row_addr = '0;

    pixel_write_t pixel_writes_due [$];
    int mismatches = 0;
    int pixels_checked = 0;
    int words_counted = 0;
    int burst_left = 0;
    int quiet_cycles = 0;
    rx_mode_t rx_mode = RX_OPEN;
    int rx_left = 0;
    int rx_tick = 0;

    task automatic note_register(input logic [2:0] idx, input logic [31:0] value);
        case (idx)
            REG_CLIP_LEFT:   clip_l = int'($signed(value[11:0]));
            REG_CLIP_TOP:    clip_t = int'($signed(value[11:0]));
            REG_CLIP_RIGHT:  clip_r = int'($signed(value[11:0]));
            REG_CLIP_BOTTOM: clip_b = int'($signed(value[11:0]));
            REG_TRANSPARENT: skip_code = value[7:0];
            REG_ROW_PITCH:   pitch_bytes = value[13:0];
            REG_FRAME_BASE:  fb_base = value;
            default: ;
        endcase
    endtask

    task automatic predict_pixel_write(input blit_word_t w);
        int x, y, wd, ht, x2, y2, j, lo, hi, first, rows;
        bit hidden, moved;
        logic [31:0] base;
        pixel_write_t px;
        case (w.action)
            ACT_PALETTE:
            begin
                pal_color[w.data_byte] = w.palette_color;
                if (!pal_loaded[w.data_byte])
                    loaded_idx.push_back(w.data_byte);
                pal_loaded[w.data_byte] = 1'b1;
            end
            ACT_START:
            begin
                spr_on = 1'b0;
                skip_wait = 1'b0;
                col = 0;
                row = 0;
                wd = (w.sprite_width > SIZE_CAP) ? SIZE_CAP : int'(w.sprite_width);
                ht = (w.sprite_height > SIZE_CAP) ? SIZE_CAP : int'(w.sprite_height);
                x = int'($signed(w.pos_x));
                y = int'($signed(w.pos_y));
                x2 = x + wd - 1;
                y2 = y + ht - 1;
                lo = 0;
                hi = wd - 1;
                first = 0;
                rows = ht;
                hidden = (wd == 0 || ht == 0);
                if (!hidden && w.clip_enable)
                begin
                    hidden = (x > clip_r || x2 < clip_l || y > clip_b || y2 < clip_t);
                    if (y < clip_t) first = clip_t - y;
                    if (y2 > clip_b) rows = clip_b - y + 1;
                    if (x < clip_l) lo = clip_l - x;
                    if (x2 > clip_r) hi = clip_r - x;
                end
                if (!hidden)
                begin
                    base = (w.target_base == 0) ? fb_base : w.target_base;
                    row_addr = base + 32'(y * int'(pitch_bytes >> 1)) + 32'(x);
                    spr_w = wd;
                    spr_mirror = w.mirror;
                    row_first = first;
                    row_count = rows;
                    vis_lo = lo;
                    vis_hi = hi;
                    spr_on = 1'b1;
                end
            end
            ACT_DATA:
            if (spr_on)
            begin
                moved = 1'b1;
                if (skip_wait)
                begin
                    skip_wait = 1'b0;
                    col += int'(w.data_byte);
                end
                else if (w.data_byte == skip_code)
                begin
                    skip_wait = 1'b1;
                    moved = 1'b0;
                end
                else
                begin
                    j = spr_mirror ? spr_w - 1 - col : col;
                    if (row >= row_first && j >= vis_lo && j <= vis_hi)
                    begin
                        px.addr = row_addr + 32'(j);
                        px.color = pal_color[w.data_byte];
                        pixel_writes_due.push_back(px);
                    end
                    col++;
                end
                if (moved && col >= spr_w)
                begin
                    col = 0;
                    row++;
                    row_addr += 32'(pitch_bytes >> 1);
                    if (row >= row_count)
                        spr_on = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    // A byte that would be looked up in the palette is steered to a loaded entry.
    function automatic logic [7:0] usable_index(input logic [7:0] b);
        logic [7:0] c;
        if ((spr_on && skip_wait) || b == skip_code || pal_loaded[b])
            return b;
        do
            c = loaded_idx[$urandom_range(loaded_idx.size() - 1)];
        while (c == skip_code);
        return c;
    endfunction

    function automatic blit_word_t random_word(input logic [1:0] act);
        blit_word_t w;
        w.action = act;
        w.data_byte = 8'($urandom);
        w.palette_color = 16'($urandom);
        w.pos_x = 12'($urandom);
        w.pos_y = 12'($urandom);
        w.sprite_width = 11'($urandom);
        w.sprite_height = 11'($urandom);
        w.mirror = 1'($urandom);
        w.clip_enable = 1'($urandom);
        w.target_base = $urandom;
        return w;
    endfunction

    function automatic blit_word_t palette_word(input logic [7:0] idx, input logic [15:0] c);
        blit_word_t w;
        w = random_word(ACT_PALETTE);
        w.data_byte = idx;
        w.palette_color = c;
        return w;
    endfunction

    function automatic blit_word_t data_word(input logic [7:0] b);
        blit_word_t w;
        w = random_word(ACT_DATA);
        w.data_byte = usable_index(b);
        return w;
    endfunction

    function automatic blit_word_t start_word(input int x, input int y, input int wd,
                                              input int ht, input bit mir, input bit clip,
                                              input logic [31:0] base);
        blit_word_t w;
        w = random_word(ACT_START);
        w.pos_x = 12'(x);
        w.pos_y = 12'(y);
        w.sprite_width = 11'(wd);
        w.sprite_height = 11'(ht);
        w.mirror = mir;
        w.clip_enable = clip;
        w.target_base = base;
        return w;
    endfunction

    task automatic send_word(input blit_word_t w);
        if (burst_left == 0)
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
        in_valid <= 1'b1;
        action <= w.action;
        data_byte <= w.data_byte;
        palette_color <= w.palette_color;
        pos_x <= w.pos_x;
        pos_y <= w.pos_y;
        sprite_width <= w.sprite_width;
        sprite_height <= w.sprite_height;
        mirror <= w.mirror;
        clip_enable <= w.clip_enable;
        target_base <= w.target_base;
        do
            @(posedge clk);
        while (!in_ready);
        if (!(w.action == ACT_UNUSED || (w.action == ACT_DATA && !spr_on)))
            words_counted++;
        predict_pixel_write(w);
        burst_left--;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic settle_block(input int tail);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pixel_writes_due.size() > 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    // The caller lowers cfg_valid after its last write.
    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        note_register(idx, value);
    endtask

    task automatic apply_setting(input int k);
        int l, t, r, b;
        logic [7:0] code;
        logic [13:0] pitch;
        logic [31:0] fb;
        code = 8'($urandom);
        fb = $urandom;
        case (k)
            0:
            begin
                l = -2048; t = -2048; r = 2047; b = 2047;
                code = 8'd0; pitch = 14'd8192; fb = 32'hFFFF_FFFF;
            end
            1:
            begin
                l = -3; t = -2; r = 4; b = 3;
                code = 8'd255; pitch = 14'd2; fb = 32'd0;
            end
            2:
            begin
                l = 5; t = 3; r = -5; b = -3;
                pitch = 14'd1;
            end
            3:
            begin
                l = 2047; t = -2048; r = 2047; b = -2048;
                pitch = 14'd0;
            end
            default:
            begin
                l = $urandom_range(0, 60) - 40;
                t = $urandom_range(0, 40) - 20;
                r = l + $urandom_range(0, 40);
                b = t + $urandom_range(0, 30);
                pitch = $urandom_range(0, 1) ? 14'($urandom_range(2, 8192)) : 14'($urandom);
            end
        endcase
        write_register(REG_CLIP_LEFT, 32'(l));
        write_register(REG_CLIP_TOP, 32'(t));
        write_register(REG_CLIP_RIGHT, 32'(r));
        write_register(REG_CLIP_BOTTOM, 32'(b));
        write_register(REG_TRANSPARENT, 32'(code));
        write_register(REG_ROW_PITCH, 32'(pitch));
        write_register(REG_FRAME_BASE, fb);
        if (k == 2)
            write_register(REG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_skip(input bit wide);
        int n;
        n = wide ? 255 : ($urandom_range(0, 7) == 0 ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 6));
        send_word(data_word(skip_code));
        send_word(data_word(8'(n)));
    endtask

    task automatic random_sprite();
        int pick, wd, ht, x, y, cap, n;
        bit wide;
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            send_word(palette_word(8'($urandom), 16'($urandom)));
        end
        else if (pick == 1)
        begin
            send_word(data_word(8'($urandom)));
            send_word(random_word(ACT_UNUSED));
        end
        else
        begin
            wide = ($urandom_range(0, 9) == 0);
            wd = wide ? $urandom_range(1, 2047) : $urandom_range(1, 10);
            ht = wide ? $urandom_range(1, 2047) : $urandom_range(1, 6);
            if ($urandom_range(0, 29) == 0)
            begin
                if ($urandom_range(0, 1)) wd = 0; else ht = 0;
            end
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                x = clip_l + $urandom_range(0, 12) - 6;
                y = clip_t + $urandom_range(0, 8) - 4;
            end
            else if (pick < 7)
            begin
                x = clip_r - $urandom_range(0, 10);
                y = clip_b - $urandom_range(0, 5);
            end
            else
            begin
                x = $urandom_range(0, 4095) - 2048;
                y = $urandom_range(0, 4095) - 2048;
            end
            send_word(start_word(x, y, wd, ht, 1'($urandom), $urandom_range(0, 4) != 0,
                                 $urandom_range(0, 1) ? $urandom : 32'd0));
            cap = wide ? 40 : $urandom_range(8, 80);
            n = 0;
            while (spr_on && n < cap)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    send_word(data_word(8'($urandom)));
                else if (pick < 88)
                    send_skip(wide && $urandom_range(0, 3) != 0);
                else if (pick < 93)
                    send_word(palette_word(8'($urandom), 16'($urandom)));
                else if (pick < 97)
                    send_word(random_word(ACT_UNUSED));
                else
                    send_word(data_word(skip_code));
                n++;
            end
            if ($urandom_range(0, 5) == 0)
                send_word(data_word(8'($urandom)));
        end
    endtask

    task automatic test_palette_load();
        send_word(palette_word(8'd0, 16'h0000));
        send_word(palette_word(8'd255, 16'hFFFF));
        send_word(palette_word(8'd1, 16'h5A5A));
        send_word(palette_word(8'd2, 16'hA5C3));
    endtask

    task automatic test_stream_corners();
        send_word(random_word(ACT_UNUSED));
        send_word(data_word(8'd1));
        send_word(start_word(10, 10, 0, 3, 1'b0, 1'b0, 32'd0));
        send_word(data_word(8'd1));
        send_word(start_word(-2048, -2048, 2, 2, 1'b1, 1'b0, 32'hFFFF_FFFF));
        send_word(data_word(8'd255));
        send_word(data_word(skip_code));
        send_word(data_word(8'd5));
        send_word(data_word(8'd1));
        send_word(data_word(8'd255));
        send_word(data_word(8'd1));
    endtask

    task automatic test_clip_corners();
        send_word(start_word(2047, 0, 1, 1, 1'b0, 1'b1, 32'd0));
        send_word(data_word(8'd255));
        send_word(start_word(-5, 0, 2047, 1, 1'b0, 1'b1, 32'd0));
        send_word(data_word(8'd1));
        send_word(data_word(skip_code));
        send_word(data_word(8'd4));
        send_word(data_word(8'd255));
        send_word(start_word(630, -1, 12, 2047, 1'b0, 1'b1, 32'd0));
        send_word(data_word(8'd1));
        send_word(data_word(8'd1));
        send_word(data_word(skip_code));
        send_word(data_word(8'd255));
        send_word(data_word(8'd255));
        send_word(data_word(skip_code));
        send_word(data_word(8'd8));
        send_word(data_word(8'd1));
        send_word(data_word(8'd1));
    endtask

    task automatic test_random_sprites();
        int mark;
        for (int k = 0; k < SETTINGS_COUNT; k++)
        begin
            settle_block(4);
            apply_setting(k);
            mark = words_counted;
            while (words_counted - mark < PHASE_WORDS)
                random_sprite();
        end
    endtask

    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 120);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom);
            RX_SPARSE: out_ready <= (rx_tick % 5 == 0);
            default:   out_ready <= (rx_tick % 24 >= 18);
        endcase
    end

    always @(posedge clk)
    begin : check_pixels
        pixel_write_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (pixel_writes_due.size() == 0)
            begin
                $error("unexpected pixel write: address %h color %h",
                       pixel_address, pixel_color);
                mismatches++;
            end
            else
            begin
                due = pixel_writes_due.pop_front();
                pixels_checked++;
                if (pixel_address !== due.addr)
                begin
                    $error("pixel_address: expected %h, got %h", due.addr, pixel_address);
                    mismatches++;
                end
                if (pixel_color !== due.color)
                begin
                    $error("pixel_color: expected %h, got %h", due.color, pixel_color);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("Timed out with %0d pixel writes outstanding.", pixel_writes_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_palette_load();
        test_stream_corners();
        test_clip_corners();
        test_random_sprites();
        settle_block(8);
        if (pixel_writes_due.size() > 0)
            mismatches++;
        $display("Sent %0d sprite and palette words under %0d register settings plus defaults.",
                 words_counted, SETTINGS_COUNT);
        $display("Checked %0d pixel writes with %0d mismatches.", pixels_checked, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/core/rpsb_pkg.sv
rtl/core/rpsb_palette.sv
rtl/core/rpsb_decode.sv
rtl/core/rle_palette_sprite_blitter_unit.sv
rtl/core/rpsb_checker.sv
dv/tb.sv
